/* hdl/atht_pkg.sv */
// ----------------------------------------------------------------------------
// Allocation tracker hash table package
// Table geometry, slot layout, status codes and item types used by the
// tracker; the slot memory itself is generic and does not use them.
// ----------------------------------------------------------------------------
package atht_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	typedef enum logic [1:0] {
		TAG_EMPTY   = 2'd0,
		TAG_USED    = 2'd1,
		TAG_DELETED = 2'd2
	} tag_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_ZERO      = 2'd3
	} status_t;

	localparam logic CMD_RECORD  = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef struct packed {
		tag_t        tag;
		logic [31:0] key;
		logic [31:0] bytes;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic        cmd;
		logic [31:0] addr;
		logic [31:0] size;
	} in_item_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] freed_size;
		logic [47:0] live_bytes;
		logic [47:0] peak_bytes;
	} out_item_t;

endpackage

/* hdl/atht_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module atht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/allocation_tracker_hash_table_unit.sv */
// Sequencing: a record or release reads its home slot in S_READ and then checks slots in
// S_CHECK until it ends; a zero-size record answers in the next cycle. With a depth that is
// not a power of two, S_MOD and S_FOLD first work out the home slot by reciprocal multiply.
// Throughput: one item at a time, one slot probed per cycle through the slot memory's read port.
// Reset: a clearing pass marks every slot empty, with busy high.
// Results appear on done for a single cycle; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// Allocation tracker hash table
// Open-addressed table of live allocations with linear probing and
// tombstones, keeping a saturating running total and its peak.
// ----------------------------------------------------------------------------
module allocation_tracker_hash_table_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  atht_pkg::in_item_t  req,
	output logic                busy,
	output logic                done,
	output atht_pkg::out_item_t result
);
	import atht_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_FOLD,
		S_READ,
		S_CHECK
	} state_t;

	localparam bit DEPTH_POW2 = ((TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
	localparam logic [IDX_W:0]   DEPTH_X  = (IDX_W + 1)'(TABLE_DEPTH);
	localparam logic [31:0]      MOD_RECIP = 32'((64'd1 << 32) / TABLE_DEPTH);

	state_t          state_q;
	in_item_t        req_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] n_q;
	logic [IDX_W-1:0] clr_q;
	logic [31:0]      quot_q;
	logic [47:0]      total_q;
	logic [47:0]      peak_q;

	logic [IDX_W-1:0] pos_nx;
	logic [63:0]      prod;
	logic [IDX_W:0]   rem_est;
	logic [IDX_W-1:0] rem_nx;
	logic             last;
	logic             key_hit;
	logic [48:0]      sum;
	logic [47:0]      total_add;
	logic [47:0]      total_sub;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	slot_t            ram_wdata;
	logic [IDX_W-1:0] ram_raddr;
	slot_t            slot;
	logic [SLOT_W-1:0] ram_rdata;

	assign slot = slot_t'(ram_rdata);

	assign pos_nx  = (pos_q == LAST_IDX) ? '0 : pos_q + 1'b1;
	assign last    = (n_q == LAST_IDX);
	assign key_hit = (slot.tag == TAG_USED) && (slot.key == req_q.addr);

	// The truncated reciprocal gives the quotient or one less, so the remainder
	// lies below twice the depth and one compare and subtract finishes it.
	assign prod    = {32'd0, req_q.addr} * {32'd0, MOD_RECIP};
	assign rem_est = req_q.addr[IDX_W:0] - quot_q[IDX_W:0] * DEPTH_X;
	assign rem_nx  = (rem_est >= DEPTH_X) ? IDX_W'(rem_est - DEPTH_X) : rem_est[IDX_W-1:0];

	assign sum       = {1'b0, total_q} + {17'd0, req_q.size};
	assign total_add = sum[48] ? '1 : sum[47:0];
	assign total_sub = (total_q >= {16'd0, slot.bytes}) ? total_q - {16'd0, slot.bytes} : '0;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos_q;
		ram_wdata = '{tag: TAG_USED, key: req_q.addr, bytes: req_q.size};
		if (state_q == S_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '{tag: TAG_EMPTY, key: '0, bytes: '0};
		end else if (state_q == S_CHECK) begin
			if (req_q.cmd == CMD_RECORD) begin
				ram_we = (slot.tag != TAG_USED);
			end else begin
				ram_we    = (slot.tag != TAG_EMPTY) && key_hit;
				ram_wdata = '{tag: TAG_DELETED, key: slot.key, bytes: slot.bytes};
			end
		end
	end

	// While probing, the next slot is read in the same cycle the current one is checked.
	assign ram_raddr = (state_q == S_CHECK) ? pos_nx : pos_q;

	atht_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(TABLE_DEPTH)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			req_q   <= '0;
			pos_q   <= '0;
			n_q     <= '0;
			clr_q   <= '0;
			quot_q  <= '0;
			total_q <= '0;
			peak_q  <= '0;
			done    <= 1'b0;
			result  <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_IDX) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						req_q <= req;
						n_q   <= '0;
						if (req.cmd == CMD_RECORD && req.size == 32'd0) begin
							done   <= 1'b1;
							result <= '{status: ST_ZERO, freed_size: '0,
								live_bytes: total_q, peak_bytes: peak_q};
						end else if (DEPTH_POW2) begin
							pos_q   <= req.addr[IDX_W-1:0];
							state_q <= S_READ;
						end else begin
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					quot_q  <= prod[63:32];
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					pos_q   <= rem_nx;
					state_q <= S_READ;
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (req_q.cmd == CMD_RECORD) begin
						if (slot.tag != TAG_USED) begin
							total_q <= total_add;
							if (total_add > peak_q) begin
								peak_q <= total_add;
							end
							done    <= 1'b1;
							result  <= '{status: ST_OK, freed_size: '0, live_bytes: total_add,
								peak_bytes: (total_add > peak_q) ? total_add : peak_q};
							state_q <= S_IDLE;
						end else if (last) begin
							done    <= 1'b1;
							result  <= '{status: ST_FULL, freed_size: '0,
								live_bytes: total_q, peak_bytes: peak_q};
							state_q <= S_IDLE;
						end else begin
							pos_q <= pos_nx;
							n_q   <= n_q + 1'b1;
						end
					end else begin
						if (slot.tag == TAG_EMPTY || (!key_hit && last)) begin
							done    <= 1'b1;
							result  <= '{status: ST_NOT_FOUND, freed_size: '0,
								live_bytes: total_q, peak_bytes: peak_q};
							state_q <= S_IDLE;
						end else if (key_hit) begin
							total_q <= total_sub;
							done    <= 1'b1;
							result  <= '{status: ST_OK, freed_size: slot.bytes,
								live_bytes: total_sub, peak_bytes: peak_q};
							state_q <= S_IDLE;
						end else begin
							pos_q <= pos_nx;
							n_q   <= n_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
